FILE: rtl/core/edgc_pkg.sv
// Shared types and register codes for the edge interface cut block.
`default_nettype none
package edgc_pkg;

	// Configuration register indexes
	localparam logic [2:0] REG_BOX_MIN_X = 3'd0;
	localparam logic [2:0] REG_BOX_MIN_Y = 3'd1;
	localparam logic [2:0] REG_BOX_MIN_Z = 3'd2;
	localparam logic [2:0] REG_BOX_MAX_X = 3'd3;
	localparam logic [2:0] REG_BOX_MAX_Y = 3'd4;
	localparam logic [2:0] REG_BOX_MAX_Z = 3'd5;

	// Q1.15 constants
	localparam logic [15:0] ONE_Q15  = 16'd32768;
	localparam logic [15:0] HALF_Q15 = 16'd16384;
	localparam int          FRAC_BITS = 15;

	// Class of one fraction lane after normalisation
	typedef enum logic [1:0] {
		CLS_ZERO = 2'd0,
		CLS_ONE  = 2'd1,
		CLS_DIV  = 2'd2
	} edgc_cls_t;

	// Per-edge control flags carried from front to back
	typedef struct packed {
		logic cut;    // labels differ
		logic bmode;  // exactly one end outside
		logic flip;   // first end is the outside one
	} edgc_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/edgc_front.sv
// Front end: classifies an edge and forms the normalised fraction operands.
`default_nettype none
module edgc_front #(
	parameter int CB = 16,
	parameter int VB = 16,
	parameter int LB = 4,
	parameter int NW = 20
) (
	input  wire logic [3*CB-1:0]          first_position,
	input  wire logic [3*CB-1:0]          second_position,
	input  wire logic [LB-1:0]            first_label,
	input  wire logic [LB-1:0]            second_label,
	input  wire logic                     first_outside,
	input  wire logic                     second_outside,
	input  wire logic signed [VB-1:0]     own_value_first,
	input  wire logic signed [VB-1:0]     own_value_second,
	input  wire logic signed [VB-1:0]     other_value_first,
	input  wire logic signed [VB-1:0]     other_value_second,
	input  wire logic [2:0][15:0]         box_lo,
	input  wire logic [2:0][15:0]         box_hi,
	output edgc_pkg::edgc_ctl_t           ctl,
	output logic [LB-1:0]                 label,
	output logic [3*CB-1:0]               from_pos,
	output logic [3*(CB+1)-1:0]           diff_pos,
	output edgc_pkg::edgc_cls_t [2:0]     lane_cls,
	output logic [3*(NW-1)-1:0]           lane_num,
	output logic [3*(NW-1)-1:0]           lane_den
);
	import edgc_pkg::*;

	localparam int UW = NW - 1;

	logic signed [CB-1:0] p1 [3];
	logic signed [CB-1:0] p2 [3];
	logic signed [CB-1:0] from_c [3];
	logic signed [CB-1:0] to_c [3];
	logic                 bmode;

	// Mode and end selection
	assign bmode = first_outside ^ second_outside;
	assign ctl.cut   = (first_label != second_label);
	assign ctl.bmode = bmode;
	assign ctl.flip  = bmode & first_outside;
	assign label = (bmode && (second_label < first_label)) ? second_label : first_label;

	genvar i;
	generate
		for (i = 0; i < 3; i++) begin : g_lane
			logic signed [NW-1:0] from_e, to_e, lo_e, hi_e;
			logic signed [NW-1:0] raw_num, raw_den, n, d;
			logic signed [CB:0]   diff;
			logic                 active;

			assign p1[i] = first_position[i*CB +: CB];
			assign p2[i] = second_position[i*CB +: CB];
			assign from_c[i] = ctl.flip ? p2[i] : p1[i];
			assign to_c[i]   = ctl.flip ? p1[i] : p2[i];
			assign from_e = NW'(from_c[i]);
			assign to_e   = NW'(to_c[i]);
			assign lo_e   = NW'($signed(box_lo[i]));
			assign hi_e   = NW'($signed(box_hi[i]));
			assign diff   = (CB+1)'(to_c[i]) - (CB+1)'(from_c[i]);
			assign from_pos[i*CB +: CB]         = from_c[i];
			assign diff_pos[i*(CB+1) +: (CB+1)] = diff;

			// Raw operands: box crossing per axis, or the field ratio on lane 0
			always_comb begin
				raw_num = '0;
				raw_den = '0;
				active  = 1'b0;
				if (bmode) begin
					raw_den = to_e - from_e;
					if (to_e > hi_e) begin
						raw_num = hi_e - from_e;
						active  = 1'b1;
					end else if (to_e < lo_e) begin
						raw_num = lo_e - from_e;
						active  = 1'b1;
					end
				end else if (i == 0) begin
					raw_num = NW'(own_value_first) - NW'(other_value_first);
					raw_den = NW'(other_value_second) - NW'(own_value_second) + raw_num;
					active  = 1'b1;
				end
			end

			// Sign normalisation and classification
			always_comb begin
				n = (raw_den < 0) ? -raw_num : raw_num;
				d = (raw_den < 0) ? -raw_den : raw_den;
				if (!active)
					lane_cls[i] = CLS_ONE;
				else if (d == 0 || n <= 0)
					lane_cls[i] = CLS_ZERO;
				else if (n >= d)
					lane_cls[i] = CLS_ONE;
				else
					lane_cls[i] = CLS_DIV;
			end
			assign lane_num[i*UW +: UW] = n[UW-1:0];
			assign lane_den[i*UW +: UW] = d[UW-1:0];
		end
	endgenerate

endmodule
`default_nettype wire

FILE: rtl/core/edgc_queue.sv
// Short first-in first-out queue between front and back.
`default_nettype none
module edgc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	output logic [WIDTH-1:0]      rd_data,
	output logic                  full,
	output logic                  empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [AW:0]      cnt_q;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign rd_data = slot_q[rd_ptr_q];

	// Storage
	always_ff @(posedge clk) begin
		if (wr_en)
			slot_q[wr_ptr_q] <= wr_data;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en)
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (rd_en)
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (wr_en && !rd_en)
				cnt_q <= cnt_q + 1'b1;
			else if (rd_en && !wr_en)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/edgc_back.sv
// Back end: pipelined fraction division, interpolation and result register.
`default_nettype none
module edgc_back #(
	parameter int CB = 16,
	parameter int LB = 4,
	parameter int NW = 20
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_take,
	input  wire edgc_pkg::edgc_ctl_t      in_ctl,
	input  wire logic [LB-1:0]            in_label,
	input  wire logic [3*CB-1:0]          in_from,
	input  wire logic [3*(CB+1)-1:0]      in_diff,
	input  wire logic [2:0][1:0]          in_cls,
	input  wire logic [3*(NW-1)-1:0]      in_num,
	input  wire logic [3*(NW-1)-1:0]      in_den,
	input  wire logic [15:0]              in_m1,
	input  wire logic [15:0]              in_m2,
	output logic                          empty,
	input  wire logic                     pop,
	output logic                          cut_made,
	output logic [3*CB-1:0]               cut_position,
	output logic [LB-1:0]                 cut_label,
	output logic                          violating,
	output logic                          nearer_second,
	output logic [15:0]                   cut_fraction,
	output logic                          boundary_mode
);
	import edgc_pkg::*;

	localparam int UW = NW - 1;
	localparam int NS = FRAC_BITS + 1;      // division stages incl. load
	localparam int PW = CB + 1 + 17;        // product width

	typedef struct packed {
		edgc_ctl_t          ctl;
		logic [LB-1:0]      label;
		logic [3*CB-1:0]    from;
		logic [3*(CB+1)-1:0] diff;
		logic [15:0]        m1;
		logic [15:0]        m2;
	} meta_t;

	logic en;
	logic out_vld_q;

	// Whole back pipeline advances unless the result register is held
	assign en      = !out_vld_q || pop;
	assign in_take = en && in_valid;
	assign empty   = !out_vld_q;

	// Division pipeline state
	logic              vld_s  [NS];
	meta_t             meta_s [NS];
	logic [UW-1:0]     rem_s  [NS][3];
	logic [UW-1:0]     den_s  [NS][3];
	logic [FRAC_BITS-1:0] quo_s [NS][3];
	edgc_cls_t         cls_s  [NS][3];

	// Load stage
	always_ff @(posedge clk) begin
		if (en) begin
			meta_s[0] <= '{ctl: in_ctl, label: in_label, from: in_from, diff: in_diff,
				m1: in_m1, m2: in_m2};
			for (int l = 0; l < 3; l++) begin
				rem_s[0][l] <= in_num[l*UW +: UW];
				den_s[0][l] <= in_den[l*UW +: UW];
				quo_s[0][l] <= '0;
				cls_s[0][l] <= edgc_cls_t'(in_cls[l]);
			end
		end
	end

	// One quotient bit per stage, restoring form
	genvar k;
	generate
		for (k = 1; k < NS; k++) begin : g_div
			always_ff @(posedge clk) begin
				logic [UW:0] sh;
				logic        ge;
				if (en) begin
					meta_s[k] <= meta_s[k-1];
					for (int l = 0; l < 3; l++) begin
						sh = {rem_s[k-1][l], 1'b0};
						ge = (sh >= {1'b0, den_s[k-1][l]});
						rem_s[k][l] <= ge ? UW'(sh - {1'b0, den_s[k-1][l]}) : sh[UW-1:0];
						quo_s[k][l] <= {quo_s[k-1][l][FRAC_BITS-2:0], ge};
						den_s[k][l] <= den_s[k-1][l];
						cls_s[k][l] <= cls_s[k-1][l];
					end
				end
			end
		end
	endgenerate

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NS; j++)
				vld_s[j] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int j = 1; j < NS; j++)
				vld_s[j] <= vld_s[j-1];
		end
	end

	// Lane fractions and their minimum
	logic [15:0] lane_t [3];
	logic [15:0] t_min;
	always_comb begin
		for (int l = 0; l < 3; l++) begin
			case (cls_s[NS-1][l])
				CLS_ZERO: lane_t[l] = '0;
				CLS_ONE:  lane_t[l] = ONE_Q15;
				CLS_DIV:  lane_t[l] = {1'b0, quo_s[NS-1][l]};
				default:  lane_t[l] = '0;
			endcase
		end
		t_min = lane_t[0];
		if (lane_t[1] < t_min)
			t_min = lane_t[1];
		if (lane_t[2] < t_min)
			t_min = lane_t[2];
	end

	logic        vld_t_s;
	meta_t       meta_t_s;
	logic [15:0] frac_t_s;

	always_ff @(posedge clk) begin
		if (en) begin
			meta_t_s <= meta_s[NS-1];
			frac_t_s <= t_min;
		end
	end

	// Interpolation products
	logic                  vld_p_s;
	meta_t                 meta_p_s;
	logic [15:0]           frac_p_s;
	logic signed [PW-1:0]  prod_p_s [3];

	always_ff @(posedge clk) begin
		if (en) begin
			meta_p_s <= meta_t_s;
			frac_p_s <= frac_t_s;
			for (int l = 0; l < 3; l++)
				prod_p_s[l] <= PW'($signed(meta_t_s.diff[l*(CB+1) +: (CB+1)])
					* $signed({1'b0, frac_t_s}));
		end
	end

	// Rounding, flags and result fields
	logic [3*CB-1:0] pos_c;
	logic            viol_c, near_c, ge_half;
	always_comb begin
		logic signed [PW-1:0] rnd;
		for (int l = 0; l < 3; l++) begin
			rnd = (prod_p_s[l] + PW'(HALF_Q15)) >>> FRAC_BITS;
			pos_c[l*CB +: CB] = meta_p_s.from[l*CB +: CB] + rnd[CB-1:0];
		end
		viol_c = ({1'b0, frac_p_s} <= {1'b0, meta_p_s.m1})
			|| ($signed({2'b00, frac_p_s}) >= $signed(18'(ONE_Q15)) - $signed({2'b00, meta_p_s.m2}));
		ge_half = (frac_p_s >= HALF_Q15);
		near_c  = meta_p_s.ctl.flip ? !ge_half : ge_half;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cut_made      <= meta_p_s.ctl.cut;
			cut_position  <= meta_p_s.ctl.cut ? pos_c : '0;
			cut_label     <= meta_p_s.ctl.cut ? meta_p_s.label : '0;
			violating     <= meta_p_s.ctl.cut & viol_c;
			nearer_second <= meta_p_s.ctl.cut & near_c;
			cut_fraction  <= meta_p_s.ctl.cut ? frac_p_s : '0;
			boundary_mode <= meta_p_s.ctl.cut & meta_p_s.ctl.bmode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_t_s   <= 1'b0;
			vld_p_s   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_t_s   <= vld_s[NS-1];
			vld_p_s   <= vld_t_s;
			out_vld_q <= vld_p_s;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/edge_interface_cut_top.sv
// Top level of the edge interface cut block: registers, front, queue and back.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+------------------------------------------
//  input    | push / full           | positions, labels, outside flags, values
//  result   | pop / empty           | cut fields, fraction, flags
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One edge per cycle is taken while the queue is not full; each result passes through
// the load stage, the fifteen one-bit division stages and the minimum, multiply and
// result stages. Reset clears the box registers to the full range and empties the
// queue and pipeline. A held result stalls the back pipeline; the front keeps
// taking edges until the four-entry queue is full.
`default_nettype none
module edge_interface_cut_top #(
	parameter int COORD_BITS = 16,
	parameter int VALUE_BITS = 16,
	parameter int LABEL_BITS = 4
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [3*COORD_BITS-1:0]      first_position,
	input  wire logic [3*COORD_BITS-1:0]      second_position,
	input  wire logic [LABEL_BITS-1:0]        first_label,
	input  wire logic [LABEL_BITS-1:0]        second_label,
	input  wire logic                         first_outside,
	input  wire logic                         second_outside,
	input  wire logic signed [VALUE_BITS-1:0] own_value_first,
	input  wire logic signed [VALUE_BITS-1:0] own_value_second,
	input  wire logic signed [VALUE_BITS-1:0] other_value_first,
	input  wire logic signed [VALUE_BITS-1:0] other_value_second,
	input  wire logic [15:0]                  first_margin,
	input  wire logic [15:0]                  second_margin,
	output logic                              empty,
	input  wire logic                         pop,
	output logic                              cut_made,
	output logic [3*COORD_BITS-1:0]           cut_position,
	output logic [LABEL_BITS-1:0]             cut_label,
	output logic                              violating,
	output logic                              nearer_second,
	output logic [15:0]                       cut_fraction,
	output logic                              boundary_mode,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [2:0]                   cfg_index,
	input  wire logic [15:0]                  cfg_data
);
	import edgc_pkg::*;

	localparam int CB  = COORD_BITS;
	localparam int EW  = ((CB > 16) ? CB : 16) + 1;
	localparam int NW  = ((EW + 1 > VALUE_BITS + 2) ? EW + 1 : VALUE_BITS + 2) + 1;
	localparam int UW  = NW - 1;
	localparam int QW  = 3 + LABEL_BITS + 3*CB + 3*(CB+1) + 6 + 6*UW + 32;
	localparam int Q_DEPTH = 4;

	// Bounding box registers
	logic [2:0][15:0] box_lo_q, box_hi_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_lo_q <= {3{16'h8000}};
			box_hi_q <= {3{16'h7fff}};
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BOX_MIN_X: box_lo_q[0] <= cfg_data;
				REG_BOX_MIN_Y: box_lo_q[1] <= cfg_data;
				REG_BOX_MIN_Z: box_lo_q[2] <= cfg_data;
				REG_BOX_MAX_X: box_hi_q[0] <= cfg_data;
				REG_BOX_MAX_Y: box_hi_q[1] <= cfg_data;
				REG_BOX_MAX_Z: box_hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Front
	edgc_ctl_t                 f_ctl;
	logic [LABEL_BITS-1:0]     f_label;
	logic [3*CB-1:0]           f_from;
	logic [3*(CB+1)-1:0]       f_diff;
	edgc_cls_t [2:0]           f_cls;
	logic [3*UW-1:0]           f_num, f_den;

	edgc_front #(.CB(CB), .VB(VALUE_BITS), .LB(LABEL_BITS), .NW(NW)) u_front (
		.first_position    (first_position),
		.second_position   (second_position),
		.first_label       (first_label),
		.second_label      (second_label),
		.first_outside     (first_outside),
		.second_outside    (second_outside),
		.own_value_first   (own_value_first),
		.own_value_second  (own_value_second),
		.other_value_first (other_value_first),
		.other_value_second(other_value_second),
		.box_lo            (box_lo_q),
		.box_hi            (box_hi_q),
		.ctl               (f_ctl),
		.label             (f_label),
		.from_pos          (f_from),
		.diff_pos          (f_diff),
		.lane_cls          (f_cls),
		.lane_num          (f_num),
		.lane_den          (f_den)
	);

	// Queue between front and back
	logic [QW-1:0] q_wdata, q_rdata;
	logic          q_empty, q_take;

	assign q_wdata = {f_ctl, f_label, f_from, f_diff, f_cls, f_num, f_den,
		first_margin, second_margin};

	edgc_queue #(.WIDTH(QW), .DEPTH(Q_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (push && !full),
		.wr_data(q_wdata),
		.rd_en  (q_take),
		.rd_data(q_rdata),
		.full   (full),
		.empty  (q_empty)
	);

	edgc_ctl_t             b_ctl;
	logic [LABEL_BITS-1:0] b_label;
	logic [3*CB-1:0]       b_from;
	logic [3*(CB+1)-1:0]   b_diff;
	logic [2:0][1:0]       b_cls;
	logic [3*UW-1:0]       b_num, b_den;
	logic [15:0]           b_m1, b_m2;

	assign {b_ctl, b_label, b_from, b_diff, b_cls, b_num, b_den, b_m1, b_m2} = q_rdata;

	// Back
	edgc_back #(.CB(CB), .LB(LABEL_BITS), .NW(NW)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (!q_empty),
		.in_take      (q_take),
		.in_ctl       (b_ctl),
		.in_label     (b_label),
		.in_from      (b_from),
		.in_diff      (b_diff),
		.in_cls       (b_cls),
		.in_num       (b_num),
		.in_den       (b_den),
		.in_m1        (b_m1),
		.in_m2        (b_m2),
		.empty        (empty),
		.pop          (pop),
		.cut_made     (cut_made),
		.cut_position (cut_position),
		.cut_label    (cut_label),
		.violating    (violating),
		.nearer_second(nearer_second),
		.cut_fraction (cut_fraction),
		.boundary_mode(boundary_mode)
	);

endmodule
`default_nettype wire

FILE: dv/tb_edge_interface_cut_top.sv
// Self-checking testbench for the edge interface cut block with its own cut predictor.
`default_nettype none
module tb_edge_interface_cut_top;
	import edgc_pkg::*;

	// One edge as driven on the input ports
	typedef struct {
		logic [47:0] pos1, pos2;
		logic [3:0]  lab1, lab2;
		logic        out1, out2;
		logic [15:0] a1, a2, b1, b2;
		logic [15:0] m1, m2;
	} edge_t;

	// One cut as seen on the result ports
	typedef struct {
		logic        made;
		logic [47:0] pos;
		logic [3:0]  lab;
		logic        viol;
		logic        near2;
		logic [15:0] frac;
		logic        bmode;
	} cut_t;

	// Cut predictor: box copy, expected cuts and mismatch count
	class cut_predictor;
		longint box_lo[3];
		longint box_hi[3];
		cut_t   expected_cuts[$];
		int     errors;
		int     cuts_seen;
		int     boundary_seen;

		function new();
			for (int i = 0; i < 3; i++) begin
				box_lo[i] = -32768;
				box_hi[i] = 32767;
			end
			errors = 0;
			cuts_seen = 0;
			boundary_seen = 0;
		endfunction

		function void set_reg(logic [2:0] idx, logic [15:0] data);
			if (idx <= REG_BOX_MIN_Z)
				box_lo[idx] = longint'($signed(data));
			else if (idx <= REG_BOX_MAX_Z)
				box_hi[idx - REG_BOX_MAX_X] = longint'($signed(data));
		endfunction

		// Truncated Q1.15 quotient clamped to 0..1, zero denominator gives 0
		function longint ratio_q15(longint num, longint den);
			if (den == 0)
				return 0;
			if (den < 0) begin
				den = -den;
				num = -num;
			end
			if (num <= 0)
				return 0;
			if (num >= den)
				return longint'(ONE_Q15);
			return (num * longint'(ONE_Q15)) / den;
		endfunction

		// Round-half-up division by 2^15, floor semantics
		function longint round_q15(longint v);
			v += longint'(HALF_Q15);
			if (v >= 0)
				return v / longint'(ONE_Q15);
			return -((-v + longint'(ONE_Q15) - 1) / longint'(ONE_Q15));
		endfunction

		function cut_t predict_cut(edge_t e);
			cut_t   r;
			longint p1[3], p2[3], from_c[3], to_c[3];
			longint t, tt, c;
			logic   bm, n2;
			r = '{default: '0};
			if (e.lab1 == e.lab2)
				return r;
			for (int i = 0; i < 3; i++) begin
				p1[i] = longint'($signed(e.pos1[16*i +: 16]));
				p2[i] = longint'($signed(e.pos2[16*i +: 16]));
			end
			bm = e.out1 ^ e.out2;
			if (bm) begin
				for (int i = 0; i < 3; i++) begin
					from_c[i] = e.out1 ? p2[i] : p1[i];
					to_c[i]   = e.out1 ? p1[i] : p2[i];
				end
				t = longint'(ONE_Q15);
				for (int i = 0; i < 3; i++) begin
					tt = longint'(ONE_Q15);
					if (to_c[i] > box_hi[i])
						tt = ratio_q15(box_hi[i] - from_c[i], to_c[i] - from_c[i]);
					else if (to_c[i] < box_lo[i])
						tt = ratio_q15(box_lo[i] - from_c[i], to_c[i] - from_c[i]);
					if (tt < t)
						t = tt;
				end
				r.lab = (e.lab1 < e.lab2) ? e.lab1 : e.lab2;
				n2 = e.out1 ? (t < longint'(HALF_Q15)) : (t >= longint'(HALF_Q15));
			end else begin
				from_c = p1;
				to_c = p2;
				t = ratio_q15(longint'($signed(e.a1)) - longint'($signed(e.b1)),
					longint'($signed(e.b2)) - longint'($signed(e.a2))
					+ longint'($signed(e.a1)) - longint'($signed(e.b1)));
				r.lab = e.lab1;
				n2 = (t >= longint'(HALF_Q15));
			end
			for (int i = 0; i < 3; i++) begin
				c = from_c[i] + round_q15((to_c[i] - from_c[i]) * t);
				r.pos[16*i +: 16] = c[15:0];
			end
			r.viol  = (t <= longint'(e.m1)) || (t >= longint'(ONE_Q15) - longint'(e.m2));
			r.made  = 1'b1;
			r.near2 = n2;
			r.frac  = t[15:0];
			r.bmode = bm;
			return r;
		endfunction

		function void note_edge(edge_t e);
			cut_t r;
			r = predict_cut(e);
			expected_cuts.push_back(r);
			if (r.made)
				cuts_seen++;
			if (r.bmode)
				boundary_seen++;
		endfunction

		function void report(string field, logic [47:0] exp_v, logic [47:0] act_v);
			errors++;
			$display("%0t: mismatch %s expected %h actual %h", $time, field, exp_v, act_v);
		endfunction

		function void check_cut(cut_t got);
			cut_t exp_c;
			if (expected_cuts.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none actual pos %h", $time, got.pos);
				return;
			end
			exp_c = expected_cuts.pop_front();
			if (got.made !== exp_c.made)   report("cut_made", exp_c.made, got.made);
			if (got.pos !== exp_c.pos)     report("cut_position", exp_c.pos, got.pos);
			if (got.lab !== exp_c.lab)     report("cut_label", exp_c.lab, got.lab);
			if (got.viol !== exp_c.viol)   report("violating", exp_c.viol, got.viol);
			if (got.near2 !== exp_c.near2) report("nearer_second", exp_c.near2, got.near2);
			if (got.frac !== exp_c.frac)   report("cut_fraction", exp_c.frac, got.frac);
			if (got.bmode !== exp_c.bmode) report("boundary_mode", exp_c.bmode, got.bmode);
		endfunction
	endclass

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 30;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic        full, empty, cfg_ready;
	logic [47:0] first_position = '0, second_position = '0;
	logic [3:0]  first_label = '0, second_label = '0;
	logic        first_outside = 1'b0, second_outside = 1'b0;
	logic [15:0] own_value_first = '0, own_value_second = '0;
	logic [15:0] other_value_first = '0, other_value_second = '0;
	logic [15:0] first_margin = '0, second_margin = '0;
	logic        cfg_valid = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic        cut_made, violating, nearer_second, boundary_mode;
	logic [47:0] cut_position;
	logic [3:0]  cut_label;
	logic [15:0] cut_fraction;

	cut_predictor cuts = new();
	int send_idle = 0;
	int recv_idle = 0;
	int cycle_count = 0;
	int edges_sent = 0;

	edge_interface_cut_top dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.first_position(first_position), .second_position(second_position),
		.first_label(first_label), .second_label(second_label),
		.first_outside(first_outside), .second_outside(second_outside),
		.own_value_first(own_value_first), .own_value_second(own_value_second),
		.other_value_first(other_value_first), .other_value_second(other_value_second),
		.first_margin(first_margin), .second_margin(second_margin),
		.empty(empty), .pop(pop), .cut_made(cut_made), .cut_position(cut_position),
		.cut_label(cut_label), .violating(violating), .nearer_second(nearer_second),
		.cut_fraction(cut_fraction), .boundary_mode(boundary_mode),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Result side: check each transfer, then choose whether to stall
	always @(posedge clk) begin
		if (arst_n && pop && !empty)
			cuts.check_cut('{cut_made, cut_position, cut_label, violating,
				nearer_second, cut_fraction, boundary_mode});
		pop <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cuts.set_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_box(logic [15:0] lx, logic [15:0] ly, logic [15:0] lz,
			logic [15:0] hx, logic [15:0] hy, logic [15:0] hz);
		write_reg(REG_BOX_MIN_X, lx);
		write_reg(REG_BOX_MIN_Y, ly);
		write_reg(REG_BOX_MIN_Z, lz);
		write_reg(REG_BOX_MAX_X, hx);
		write_reg(REG_BOX_MAX_Y, hy);
		write_reg(REG_BOX_MAX_Z, hz);
	endtask

	// Drive one edge and hold it until transfer, then maybe idle
	task automatic send_edge(edge_t e);
		int gap;
		push <= 1'b1;
		first_position <= e.pos1;
		second_position <= e.pos2;
		first_label <= e.lab1;
		second_label <= e.lab2;
		first_outside <= e.out1;
		second_outside <= e.out2;
		own_value_first <= e.a1;
		own_value_second <= e.a2;
		other_value_first <= e.b1;
		other_value_second <= e.b2;
		first_margin <= e.m1;
		second_margin <= e.m2;
		do @(posedge clk); while (full);
		cuts.note_edge(e);
		edges_sent++;
		if ($urandom_range(99) < send_idle) begin
			push <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
	endtask

	// Lower push and wait until every expected cut has come out
	task automatic drain();
		push <= 1'b0;
		while (cuts.expected_cuts.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic edge_t make_edge(logic [47:0] p1, logic [47:0] p2,
			logic [3:0] l1, logic [3:0] l2, logic o1, logic o2,
			logic [15:0] a1, logic [15:0] a2, logic [15:0] b1, logic [15:0] b2,
			logic [15:0] m1, logic [15:0] m2);
		edge_t e;
		e = '{p1, p2, l1, l2, o1, o2, a1, a2, b1, b2, m1, m2};
		return e;
	endfunction

	function automatic logic [15:0] near_coord();
		return 16'($signed($urandom_range(0, 12000)) - 6000);
	endfunction

	function automatic logic [15:0] rand_value();
		if ($urandom_range(1))
			return 16'($urandom);
		return 16'($signed($urandom_range(0, 2000)) - 1000);
	endfunction

	// Random edge: mostly differing labels, positions near the box half the time
	function automatic edge_t random_edge();
		edge_t e;
		for (int i = 0; i < 3; i++) begin
			e.pos1[16*i +: 16] = $urandom_range(1) ? 16'($urandom) : near_coord();
			e.pos2[16*i +: 16] = $urandom_range(1) ? 16'($urandom) : near_coord();
		end
		e.lab1 = 4'($urandom);
		e.lab2 = ($urandom_range(99) < 15) ? e.lab1 : 4'($urandom);
		e.out1 = 1'($urandom);
		e.out2 = 1'($urandom);
		e.a1 = rand_value();
		e.a2 = rand_value();
		e.b1 = rand_value();
		e.b2 = rand_value();
		e.m1 = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 32768)) : 16'($urandom);
		e.m2 = ($urandom_range(99) < 70) ? 16'($urandom_range(0, 32768)) : 16'($urandom);
		return e;
	endfunction

	initial begin
		edge_t dir[$];
		logic [15:0] lo, hi;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed edges against a box of +-2560 units
		write_box(16'hF600, 16'hF600, 16'hF600, 16'h0A00, 16'h0A00, 16'h0A00);
		dir.push_back(make_edge('1, '0, 4'd3, 4'd3, 1'b1, 1'b0,
			16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd6));
		dir.push_back(make_edge(48'h0, 48'h0100_0200_0400, 4'd1, 4'd2, 1'b0, 1'b0,
			16'd4096, 16'd0, 16'd0, 16'd4096, 16'd0, 16'd0));
		dir.push_back(make_edge(48'h1234_5678_9ABC, 48'h0, 4'd1, 4'd2, 1'b0, 1'b0,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd100, 16'd100));
		dir.push_back(make_edge(48'h0, 48'h0100_0100_0100, 4'd5, 4'd2, 1'b1, 1'b1,
			16'd0, 16'd0, 16'd4096, 16'd8192, 16'd0, 16'd0));
		dir.push_back(make_edge(48'h0, 48'h0100_0100_0100, 4'd5, 4'd2, 1'b0, 1'b0,
			16'd8192, 16'd0, 16'd0, 16'd0, 16'd32768, 16'd32768));
		dir.push_back(make_edge(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 4'd0, 4'd15,
			1'b0, 1'b0, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h0000));
		dir.push_back(make_edge(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 4'd15, 4'd0,
			1'b1, 1'b1, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF));
		dir.push_back(make_edge(48'h0000_0000_1388, 48'h0, 4'd7, 4'd4, 1'b1, 1'b0,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		dir.push_back(make_edge(48'h0, 48'h0000_EC78_0000, 4'd7, 4'd9, 1'b0, 1'b1,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 16'd16384));
		dir.push_back(make_edge(48'h0100_0100_0100, 48'h0, 4'd2, 4'd8, 1'b1, 1'b0,
			16'd0, 16'd0, 16'd0, 16'd0, 16'd40000, 16'd40000));
		dir.push_back(make_edge(48'h0000_0000_1388, 48'h0000_0000_1388, 4'd2, 4'd8,
			1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		dir.push_back(make_edge(48'h0000_0000_1388, 48'h0000_0000_1770, 4'd2, 4'd8,
			1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		dir.push_back(make_edge(48'h8000_8000_8000, 48'h7FFF_7FFF_7FFF, 4'd9, 4'd1,
			1'b0, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF));
		dir.push_back(make_edge(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 4'd9, 4'd1,
			1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0));
		dir.push_back(make_edge(48'h0, 48'h0100_0100_0100, 4'd5, 4'd2, 1'b0, 1'b0,
			16'd4096, 16'd4095, 16'd4095, 16'd4096, 16'd0, 16'd0));
		foreach (dir[i])
			send_edge(dir[i]);
		drain();

		// Six random phases; idling pattern changes every two
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: write_box(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF);
				3: write_box(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'h8000);
				default: begin
					lo = 16'(-$signed($urandom_range(0, 5000)));
					hi = 16'($urandom_range(0, 5000));
					write_box(lo, 16'(-$signed($urandom_range(0, 5000))),
						16'(-$signed($urandom_range(0, 5000))), hi,
						16'($urandom_range(0, 5000)), 16'($urandom_range(0, 5000)));
				end
			endcase
			send_idle = (ph < 2) ? 26 : (ph < 4) ? 57 : 0;
			recv_idle = (ph < 2) ? 57 : (ph < 4) ? 26 : 0;
			for (int n = 0; n < 290; n++) begin
				send_edge(random_edge());
				// Hold off once per phase until every expected cut has come out
				if (n == 150) begin
					push <= 1'b0;
					while (cuts.expected_cuts.size() != 0)
						@(posedge clk);
				end
			end
			drain();
		end

		$display("Covered %0d edges, %0d with a cut and %0d in boundary mode,",
			edges_sent, cuts.cuts_seen, cuts.boundary_seen);
		$display("over seven box settings and three idling patterns.");
		if (cuts.errors == 0 && cuts.expected_cuts.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
